@@ hdl/idct4_pkg.sv @@
// types, constants and arithmetic helpers shared by the 4x4 inverse dct files
package idct4_pkg;

   localparam int unsigned ElemWidth = 16;
   localparam int unsigned NumElems  = 4;
   localparam int unsigned RowWidth  = ElemWidth * NumElems;

   // q16 multipliers of the butterfly
   localparam logic signed [33:0] MulSin   = 34'sd35468;
   localparam logic signed [33:0] MulCosM1 = 34'sd20091;

   localparam logic [1:0] LastIdx = 2'd3;

   typedef logic signed [15:0] elem_type;
   typedef logic signed [17:0] prod_type;
   typedef logic signed [19:0] sum_type;
   typedef logic [RowWidth-1:0] row_type;

   typedef struct packed {
      elem_type coef_col3;
      elem_type coef_col2;
      elem_type coef_col1;
      elem_type coef_col0;
   } req_payload_type;

   typedef struct packed {
      logic     last_row;
      elem_type resid_col3;
      elem_type resid_col2;
      elem_type resid_col1;
      elem_type resid_col0;
   } rsp_payload_type;

   // floor(v * 35468 / 2^16)
   function automatic prod_type mul_sin(input elem_type v);
      logic signed [33:0] p;
      p = 34'(v) * MulSin;
      return p[33:16];
   endfunction

   // floor(v * 20091 / 2^16)
   function automatic prod_type mul_cos(input elem_type v);
      logic signed [33:0] p;
      p = 34'(v) * MulCosM1;
      return p[33:16];
   endfunction

   // first pass result, wrapped to 16 bits
   function automatic elem_type wrap_col(input sum_type x);
      return x[15:0];
   endfunction

   // second pass result: (x + 4) >> 3, wrapped to 16 bits
   function automatic elem_type round_row(input sum_type x);
      sum_type t;
      t = x + 20'sd4;
      return t[18:3];
   endfunction

endpackage

@@ hdl/idct4_if.sv @@
// request and response channel interfaces of the 4x4 inverse dct

interface idct4_req_if;
   logic                       valid;
   logic                       ready;
   idct4_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface idct4_rsp_if;
   logic                       valid;
   logic                       ready;
   idct4_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/inverse_dct_4x4_top.sv @@
// 4x4 integer inverse dct: takes four coefficient rows of a block, then returns
// four residual rows. rows 0..2 of a block are taken one per cycle and written
// to the coefficient memory. the request that brings row 3 starts the transform
// and req_ch.ready stays low until the last residual row is in the output
// register: four column butterflies then four row butterflies, each of them
// four reads of a memory with a registered read, then a multiply step and a
// sum step. the response side can stall the row pass. the output register
// lets the next block's rows come in while the last row of a block waits
module inverse_dct_4x4_top (
   input logic         clock,
   input logic         reset,
   idct4_req_if.sink   req_ch,
   idct4_rsp_if.source rsp_ch
);
   import idct4_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_SUM  = 4'b1000
   } state_type;

   typedef enum logic {
      PASS_COL = 1'b0,
      PASS_ROW = 1'b1
   } pass_type;

   // coefficient rows, entry = row, element c at column c
   row_type coef_mem [NumElems];
   // column pass results, entry = column, element r at row r
   row_type mid_mem [NumElems];

   state_type       state_ff, state_in;
   pass_type        pass_ff, pass_in;
   logic [1:0]      row_cnt_ff, row_cnt_in;  // next row slot to fill
   logic [1:0]      k_ff, k_in;              // operand read index
   logic [1:0]      line_ff, line_in;        // column in first pass, row in second
   logic            rd_vld_ff;
   logic [1:0]      rd_idx_ff;
   row_type         coef_rd_ff;
   row_type         mid_rd_ff;
   elem_type        opnd_ff [NumElems];
   prod_type        sin1_ff, cos1_ff, sin3_ff, cos3_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   logic            req_acc;
   logic            out_free;
   logic            rsp_load;
   logic            mid_we;
   row_type         req_row;
   row_type         rd_row;
   elem_type        rd_elem;
   sum_type         bf_a, bf_b, bf_c, bf_d;
   sum_type         bf_o0, bf_o1, bf_o2, bf_o3;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_row      = req_ch.payload;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;
   // output register can take a row this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // operand from the registered memory read issued in the previous cycle
   assign rd_row  = (pass_ff == PASS_ROW) ? mid_rd_ff : coef_rd_ff;
   assign rd_elem = rd_row[{line_ff, 4'b0000} +: ElemWidth];

   // shared butterfly, sum stage
   assign bf_a  = sum_type'(opnd_ff[0]) + sum_type'(opnd_ff[2]);
   assign bf_b  = sum_type'(opnd_ff[0]) - sum_type'(opnd_ff[2]);
   assign bf_c  = sum_type'(sin1_ff) - (sum_type'(opnd_ff[3]) + sum_type'(cos3_ff));
   assign bf_d  = (sum_type'(opnd_ff[1]) + sum_type'(cos1_ff)) + sum_type'(sin3_ff);
   assign bf_o0 = bf_a + bf_d;
   assign bf_o1 = bf_b + bf_c;
   assign bf_o2 = bf_b - bf_c;
   assign bf_o3 = bf_a - bf_d;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      row_cnt_in   = row_cnt_ff;
      k_in         = k_ff;
      line_in      = line_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_load     = 1'b0;
      mid_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               row_cnt_in = row_cnt_ff + 2'd1;
               // fourth row of the block starts the transform
               if (row_cnt_ff == LastIdx) begin
                  state_in = ST_READ;
                  pass_in  = PASS_COL;
                  line_in  = 2'd0;
                  k_in     = 2'd0;
               end
            end
         end
         ST_READ: begin
            k_in = k_ff + 2'd1;
            if (k_ff == LastIdx) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (pass_ff == PASS_COL) begin
               mid_we   = 1'b1;
               line_in  = line_ff + 2'd1;
               state_in = ST_READ;
               if (line_ff == LastIdx) begin
                  pass_in = PASS_ROW;
               end
            end else if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               line_in      = line_ff + 2'd1;
               state_in     = (line_ff == LastIdx) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_COL;
         row_cnt_ff   <= 2'd0;
         k_ff         <= 2'd0;
         line_ff      <= 2'd0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         row_cnt_ff   <= row_cnt_in;
         k_ff         <= k_in;
         line_ff      <= line_in;
         rd_vld_ff    <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // coefficient memory, written by requests, read by the column pass
   always_ff @(posedge clock) begin
      if (req_acc) begin
         coef_mem[row_cnt_ff] <= req_row;
      end
      coef_rd_ff <= coef_mem[k_ff];
   end

   // intermediate memory, written by the column pass, read by the row pass
   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem[line_ff] <= {wrap_col(bf_o3), wrap_col(bf_o2),
                              wrap_col(bf_o1), wrap_col(bf_o0)};
      end
      mid_rd_ff <= mid_mem[k_ff];
   end

   // operand gather, multiply stage and output register
   always_ff @(posedge clock) begin
      rd_idx_ff <= k_ff;
      if (rd_vld_ff) begin
         opnd_ff[rd_idx_ff] <= rd_elem;
      end
      if (state_ff == ST_MUL) begin
         // operand 3 arrives from memory in this cycle
         sin1_ff <= mul_sin(opnd_ff[1]);
         cos1_ff <= mul_cos(opnd_ff[1]);
         sin3_ff <= mul_sin(rd_elem);
         cos3_ff <= mul_cos(rd_elem);
      end
      if (rsp_load) begin
         rsp_data_ff.resid_col0 <= round_row(bf_o0);
         rsp_data_ff.resid_col1 <= round_row(bf_o1);
         rsp_data_ff.resid_col2 <= round_row(bf_o2);
         rsp_data_ff.resid_col3 <= round_row(bf_o3);
         rsp_data_ff.last_row   <= (line_ff == LastIdx);
      end
   end

endmodule

@@ hdl/idct4_checker.sv @@
// port level checks of the 4x4 inverse dct and their binding to the top level
module idct4_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input idct4_pkg::rsp_payload_type rsp_payload
);
   import idct4_pkg::*;

   logic [1:0] req_seen_ff;
   logic       req_acc;

   assign req_acc = req_valid && req_ready;

   // rows of the current block seen on the request side
   always_ff @(posedge clock) begin
      if (reset) begin
         req_seen_ff <= 2'd0;
      end else if (req_acc) begin
         req_seen_ff <= req_seen_ff + 2'd1;
      end
   end

   // a stalled response keeps its row
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // fourth row of a block closes the request side
   a_block_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_seen_ff == LastIdx) |=> !req_ready)
      else $error("request taken during transform");

   // rows before the last are produced while requests are held off
   a_mid_rows_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !rsp_payload.last_row |-> !req_ready)
      else $error("response row outside transform");

   // loading the last row of a block reopens the request side
   a_last_row_opens: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_payload.last_row |-> req_ready)
      else $error("requests still held after last row");

endmodule

bind inverse_dct_4x4_top idct4_checker u_idct4_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
